[rtl/core/hrtu_pkg.sv]
package hrtu_pkg;

	// Register file geometry.
	localparam int NumRegs   = 32;
	localparam int RegIdxW   = 5;
	localparam int HalfW     = 64;
	localparam int FloatW    = 32;

	// Instruction codes.
	localparam logic [4:0] OP_MFHI     = 5'd0;
	localparam logic [4:0] OP_MFLO     = 5'd1;
	localparam logic [4:0] OP_MOVN     = 5'd2;
	localparam logic [4:0] OP_MOVZ     = 5'd3;
	localparam logic [4:0] OP_MTHI     = 5'd4;
	localparam logic [4:0] OP_MTLO     = 5'd5;
	localparam logic [4:0] OP_MFHI1    = 5'd6;
	localparam logic [4:0] OP_MFLO1    = 5'd7;
	localparam logic [4:0] OP_MTHI1    = 5'd8;
	localparam logic [4:0] OP_MTLO1    = 5'd9;
	localparam logic [4:0] OP_PMFHI    = 5'd10;
	localparam logic [4:0] OP_PMFLO    = 5'd11;
	localparam logic [4:0] OP_PMTHI    = 5'd12;
	localparam logic [4:0] OP_PMTLO    = 5'd13;
	localparam logic [4:0] OP_PMFHL    = 5'd14;
	localparam logic [4:0] OP_PMTHL    = 5'd15;
	localparam logic [4:0] OP_MFC1     = 5'd16;
	localparam logic [4:0] OP_MOV_S    = 5'd17;
	localparam logic [4:0] OP_MTC1     = 5'd18;
	localparam logic [4:0] OP_LOAD     = 5'd19;

	// PMFHL modes, carried in the shift field.
	localparam logic [4:0] FHL_LW  = 5'd0;
	localparam logic [4:0] FHL_UW  = 5'd1;
	localparam logic [4:0] FHL_SLW = 5'd2;
	localparam logic [4:0] FHL_LH  = 5'd3;
	localparam logic [4:0] FHL_SH  = 5'd4;

	// Destination kinds reported with each result.
	localparam logic [2:0] KIND_NONE  = 3'd0;
	localparam logic [2:0] KIND_GPR   = 3'd1;
	localparam logic [2:0] KIND_HI    = 3'd2;
	localparam logic [2:0] KIND_LO    = 3'd3;
	localparam logic [2:0] KIND_FLOAT = 3'd4;

	// A signed doubleword saturated to a signed word, sign extended to 64 bits.
	function automatic logic [63:0] sat_dword_to_word(input logic [31:0] hw, input logic [31:0] lw);
		logic [63:0] v;
		logic [63:0] r;
		v = {hw, lw};
		if (v[63:31] == {33{v[63]}}) begin
			r = {{32{lw[31]}}, lw};
		end else if (v[63]) begin
			r = 64'hFFFF_FFFF_8000_0000;
		end else begin
			r = 64'h0000_0000_7FFF_FFFF;
		end
		return r;
	endfunction

	// A signed word saturated to a signed halfword.
	function automatic logic [15:0] sat_word_to_hword(input logic [31:0] w);
		logic [15:0] r;
		if (w[31:15] == {17{w[31]}}) begin
			r = w[15:0];
		end else if (w[31]) begin
			r = 16'h8000;
		end else begin
			r = 16'h7FFF;
		end
		return r;
	endfunction

endpackage

[rtl/core/hrtu_ram.sv]
module hrtu_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/core/hilo_register_transfer_unit_top.sv]
// An accepted item passes through the states RD2 and EXE; its result is registered onto the result ports in EXE.
// The block takes no new item until it is through with the last one (busy); PMTHL gives two results.
// Each item needs two reads (rt/rd, then rs) of the single read port of each gpr memory.
// Reset clears the sequencer, HI, LO and the valid bits of the general and float registers;
// an entry never written reads as zero, so the memories need no clearing pass.
// The receiver cannot stall: each result is shown for exactly one cycle under done.
module hilo_register_transfer_unit_top
	import hrtu_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [4:0]          opcode,
	input  logic [RegIdxW-1:0]  src_reg,
	input  logic [RegIdxW-1:0]  tgt_reg,
	input  logic [RegIdxW-1:0]  dst_reg,
	input  logic [4:0]          shift_field,
	input  logic                fpu_usable,
	input  logic [HalfW-1:0]    load_low,
	input  logic [HalfW-1:0]    load_high,
	output logic                done,
	output logic                fpu_exception,
	output logic [2:0]          dest_kind,
	output logic [RegIdxW-1:0]  dest_index,
	output logic [HalfW-1:0]    value_low,
	output logic [HalfW-1:0]    value_high,
	output logic                last_result
);

	// Sequencer states.
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RD2  = 2'd1;
	localparam logic [1:0] ST_EXE  = 2'd2;
	localparam logic [1:0] ST_HI2  = 2'd3;

	logic [1:0] state_q;

	// Captured item.
	logic [4:0]         op_q;
	logic [RegIdxW-1:0] rs_q;
	logic [RegIdxW-1:0] rt_q;
	logic [RegIdxW-1:0] rd_q;
	logic [4:0]         sa_q;
	logic               usable_q;
	logic [HalfW-1:0]   load_lo_q;
	logic [HalfW-1:0]   load_hi_q;

	// HI and LO registers, and valid bits for the memories.
	logic [HalfW-1:0]   hi_lower_q, hi_upper_q, lo_lower_q, lo_upper_q;
	logic [NumRegs-1:0] gvld_q;
	logic [NumRegs-1:0] fvld_q;

	// Operands collected from the first read.
	logic [HalfW-1:0]  lo_rt_q;
	logic [HalfW-1:0]  up_rd_q;
	logic [FloatW-1:0] fr_q;

	// Memory ports.
	logic [RegIdxW-1:0] glo_raddr, gup_raddr;
	logic [HalfW-1:0]   glo_rdata, gup_rdata;
	logic [FloatW-1:0]  fpr_rdata;
	logic               gpr_we, fpr_we;
	logic [RegIdxW-1:0] gpr_waddr, fpr_waddr;
	logic [HalfW-1:0]   gpr_wlo, gpr_whi;
	logic [FloatW-1:0]  fpr_wdata;

	logic accept;
	logic in_exe;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign in_exe = (state_q == ST_EXE);

	// The first read fetches rt and rd, the second fetches rs.
	assign glo_raddr = busy ? rs_q : tgt_reg;
	assign gup_raddr = busy ? rs_q : dst_reg;

	hrtu_ram #(.WIDTH(HalfW), .DEPTH(NumRegs)) u_gpr_lower (
		.clk   (clk),
		.we    (gpr_we),
		.waddr (gpr_waddr),
		.wdata (gpr_wlo),
		.raddr (glo_raddr),
		.rdata (glo_rdata)
	);

	hrtu_ram #(.WIDTH(HalfW), .DEPTH(NumRegs)) u_gpr_upper (
		.clk   (clk),
		.we    (gpr_we),
		.waddr (gpr_waddr),
		.wdata (gpr_whi),
		.raddr (gup_raddr),
		.rdata (gup_rdata)
	);

	hrtu_ram #(.WIDTH(FloatW), .DEPTH(NumRegs)) u_float (
		.clk   (clk),
		.we    (fpr_we),
		.waddr (fpr_waddr),
		.wdata (fpr_wdata),
		.raddr (dst_reg),
		.rdata (fpr_rdata)
	);

	// Second-read operands, masked by the valid bits.
	logic [HalfW-1:0] lo_rs, up_rs;
	assign lo_rs = gvld_q[rs_q] ? glo_rdata : '0;
	assign up_rs = gvld_q[rs_q] ? gup_rdata : '0;

	// Execution of the captured item.
	logic               r_exc;
	logic [2:0]         r_kind;
	logic [RegIdxW-1:0] r_idx;
	logic [HalfW-1:0]   r_lo, r_hi;
	logic               r_last;
	logic               g_wr;
	logic [RegIdxW-1:0] g_idx;
	logic [HalfW-1:0]   g_lo, g_hi;
	logic               f_wr;
	logic [RegIdxW-1:0] f_idx;
	logic [FloatW-1:0]  f_val;
	logic [HalfW-1:0]   hi_lower_n, hi_upper_n, lo_lower_n, lo_upper_n;
	logic               fhl_ok;
	logic [HalfW-1:0]   fhl_a, fhl_b;
	logic [HalfW-1:0]   mfc1_v;

	// PMFHL assembly from HI and LO.
	always_comb begin
		fhl_ok = 1'b1;
		fhl_a  = '0;
		fhl_b  = '0;
		case (sa_q)
			FHL_LW: begin
				fhl_a = {hi_lower_q[31:0], lo_lower_q[31:0]};
				fhl_b = {hi_upper_q[31:0], lo_upper_q[31:0]};
			end
			FHL_UW: begin
				fhl_a = {hi_lower_q[63:32], lo_lower_q[63:32]};
				fhl_b = {hi_upper_q[63:32], lo_upper_q[63:32]};
			end
			FHL_SLW: begin
				fhl_a = sat_dword_to_word(hi_lower_q[31:0], lo_lower_q[31:0]);
				fhl_b = sat_dword_to_word(hi_upper_q[31:0], lo_upper_q[31:0]);
			end
			FHL_LH: begin
				fhl_a = {hi_lower_q[47:32], hi_lower_q[15:0],
					lo_lower_q[47:32], lo_lower_q[15:0]};
				fhl_b = {hi_upper_q[47:32], hi_upper_q[15:0],
					lo_upper_q[47:32], lo_upper_q[15:0]};
			end
			FHL_SH: begin
				fhl_a = {sat_word_to_hword(hi_lower_q[63:32]), sat_word_to_hword(hi_lower_q[31:0]),
					sat_word_to_hword(lo_lower_q[63:32]), sat_word_to_hword(lo_lower_q[31:0])};
				fhl_b = {sat_word_to_hword(hi_upper_q[63:32]), sat_word_to_hword(hi_upper_q[31:0]),
					sat_word_to_hword(lo_upper_q[63:32]), sat_word_to_hword(lo_upper_q[31:0])};
			end
			default: begin
				fhl_ok = 1'b0;
			end
		endcase
	end

	assign mfc1_v = {{32{fr_q[31]}}, fr_q};

	// Instruction decode: register writes and the first result.
	always_comb begin
		g_wr       = 1'b0;
		g_idx      = rd_q;
		g_lo       = '0;
		g_hi       = '0;
		f_wr       = 1'b0;
		f_idx      = rd_q;
		f_val      = '0;
		hi_lower_n = hi_lower_q;
		hi_upper_n = hi_upper_q;
		lo_lower_n = lo_lower_q;
		lo_upper_n = lo_upper_q;
		r_exc      = 1'b0;
		r_kind     = KIND_NONE;
		r_idx      = '0;
		r_lo       = '0;
		r_hi       = '0;
		r_last     = 1'b1;
		if ((op_q == OP_MFC1 || op_q == OP_MOV_S || op_q == OP_MTC1) && !usable_q) begin
			r_exc = 1'b1;
		end else begin
			case (op_q)
				OP_MFHI: begin
					g_wr = 1'b1;
					g_lo = hi_lower_q;
					g_hi = up_rd_q;
				end
				OP_MFLO: begin
					g_wr = 1'b1;
					g_lo = lo_lower_q;
					g_hi = up_rd_q;
				end
				OP_MOVN: begin
					g_wr = (lo_rt_q != '0);
					g_lo = lo_rs;
					g_hi = up_rd_q;
				end
				OP_MOVZ: begin
					g_wr = (lo_rt_q == '0);
					g_lo = lo_rs;
					g_hi = up_rd_q;
				end
				OP_MTHI: begin
					hi_lower_n = lo_rs;
					r_kind     = KIND_HI;
				end
				OP_MTLO: begin
					lo_lower_n = lo_rs;
					r_kind     = KIND_LO;
				end
				OP_MFHI1: begin
					g_wr = 1'b1;
					g_lo = hi_upper_q;
					g_hi = up_rd_q;
				end
				OP_MFLO1: begin
					g_wr = 1'b1;
					g_lo = lo_upper_q;
					g_hi = up_rd_q;
				end
				OP_MTHI1: begin
					hi_upper_n = lo_rs;
					r_kind     = KIND_HI;
				end
				OP_MTLO1: begin
					lo_upper_n = lo_rs;
					r_kind     = KIND_LO;
				end
				OP_PMFHI: begin
					g_wr = 1'b1;
					g_lo = hi_lower_q;
					g_hi = hi_upper_q;
				end
				OP_PMFLO: begin
					g_wr = 1'b1;
					g_lo = lo_lower_q;
					g_hi = lo_upper_q;
				end
				OP_PMTHI: begin
					hi_lower_n = lo_rs;
					hi_upper_n = up_rs;
					r_kind     = KIND_HI;
				end
				OP_PMTLO: begin
					lo_lower_n = lo_rs;
					lo_upper_n = up_rs;
					r_kind     = KIND_LO;
				end
				OP_PMFHL: begin
					g_wr = fhl_ok;
					g_lo = fhl_a;
					g_hi = fhl_b;
				end
				OP_PMTHL: begin
					lo_lower_n = {lo_lower_q[63:32], lo_rs[31:0]};
					lo_upper_n = {lo_upper_q[63:32], up_rs[31:0]};
					hi_lower_n = {hi_lower_q[63:32], lo_rs[63:32]};
					hi_upper_n = {hi_upper_q[63:32], up_rs[63:32]};
					r_kind     = KIND_LO;
					r_last     = 1'b0;
				end
				OP_MFC1: begin
					g_wr  = 1'b1;
					g_idx = rt_q;
					g_lo  = mfc1_v;
					g_hi  = {HalfW{mfc1_v[63]}};
				end
				OP_MOV_S: begin
					f_wr  = 1'b1;
					f_idx = sa_q;
					f_val = fr_q;
				end
				OP_MTC1: begin
					f_wr  = 1'b1;
					f_idx = rd_q;
					f_val = lo_rt_q[31:0];
				end
				OP_LOAD: begin
					g_wr = 1'b1;
					g_lo = load_lo_q;
					g_hi = load_hi_q;
				end
				default: begin
					r_kind = KIND_NONE;
				end
			endcase

			// Writes to general register zero are dropped.
			if (g_wr && g_idx == '0) begin
				g_wr = 1'b0;
			end

			// Reported value follows the destination.
			if (g_wr) begin
				r_kind = KIND_GPR;
				r_idx  = g_idx;
				r_lo   = g_lo;
				r_hi   = g_hi;
			end else if (f_wr) begin
				r_kind = KIND_FLOAT;
				r_idx  = f_idx;
				r_lo   = {{(HalfW-FloatW){1'b0}}, f_val};
			end else if (r_kind == KIND_HI) begin
				r_lo = hi_lower_n;
				r_hi = hi_upper_n;
			end else if (r_kind == KIND_LO) begin
				r_lo = lo_lower_n;
				r_hi = lo_upper_n;
			end
		end
	end

	assign gpr_we    = in_exe && g_wr;
	assign gpr_waddr = g_idx;
	assign gpr_wlo   = g_lo;
	assign gpr_whi   = g_hi;
	assign fpr_we    = in_exe && f_wr;
	assign fpr_waddr = f_idx;
	assign fpr_wdata = f_val;

	// Sequencer, HI/LO and valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			hi_lower_q <= '0;
			hi_upper_q <= '0;
			lo_lower_q <= '0;
			lo_upper_q <= '0;
			gvld_q     <= '0;
			fvld_q     <= '0;
			done       <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_RD2;
					end
				end
				ST_RD2: begin
					state_q <= ST_EXE;
				end
				ST_EXE: begin
					hi_lower_q <= hi_lower_n;
					hi_upper_q <= hi_upper_n;
					lo_lower_q <= lo_lower_n;
					lo_upper_q <= lo_upper_n;
					if (g_wr) begin
						gvld_q[g_idx] <= 1'b1;
					end
					if (f_wr) begin
						fvld_q[f_idx] <= 1'b1;
					end
					done    <= 1'b1;
					state_q <= r_last ? ST_IDLE : ST_HI2;
				end
				ST_HI2: begin
					done    <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Item capture and operand collection.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q      <= opcode;
			rs_q      <= src_reg;
			rt_q      <= tgt_reg;
			rd_q      <= dst_reg;
			sa_q      <= shift_field;
			usable_q  <= fpu_usable;
			load_lo_q <= load_low;
			load_hi_q <= load_high;
		end
		if (state_q == ST_RD2) begin
			lo_rt_q <= gvld_q[rt_q] ? glo_rdata : '0;
			up_rd_q <= gvld_q[rd_q] ? gup_rdata : '0;
			fr_q    <= fvld_q[rd_q] ? fpr_rdata : '0;
		end
	end

	// Result register: first result from execution, second one reports HI.
	always_ff @(posedge clk) begin
		if (in_exe) begin
			fpu_exception <= r_exc;
			dest_kind     <= r_kind;
			dest_index    <= r_idx;
			value_low     <= r_lo;
			value_high    <= r_hi;
			last_result   <= r_last;
		end else if (state_q == ST_HI2) begin
			fpu_exception <= 1'b0;
			dest_kind     <= KIND_HI;
			dest_index    <= '0;
			value_low     <= hi_lower_q;
			value_high    <= hi_upper_q;
			last_result   <= 1'b1;
		end
	end

endmodule
